// ===== src/rcrc_pkg.sv =====
// Shared types and constants for the receive completion ring consumer.
// No dependencies; used by every module of the block.
package rcrc_pkg;

    localparam int LEN_W      = 14;
    localparam int BUF_IDX_W  = 12;
    localparam int CNT_W      = 32;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [LEN_W-1:0] BUF_LEN_RESET = 14'd2048;

    // register index of the work registers (byte address = 4 * index)
    localparam logic [0:0] REG_BUFFER_LENGTH = 1'b0;

    typedef enum logic [2:0] {
        OUT_NOT_READY = 3'd0,
        OUT_DELIVERED = 3'd1,
        OUT_REFUSED   = 3'd2,
        OUT_ERROR     = 3'd3,
        OUT_DROPPED   = 3'd4
    } outcome_t;

    typedef struct packed {
        logic                 entry_gen;
        logic                 start_flag;
        logic                 end_flag;
        logic                 error_flag;
        logic [LEN_W-1:0]     frame_length;
        logic [BUF_IDX_W-1:0] buffer_index;
        logic                 queue_room;
    } item_t;

    // fixed-width part of a result; index and slot widths follow parameters
    typedef struct packed {
        outcome_t         outcome;
        logic             refill_valid;
        logic             refill_gen;
        logic [LEN_W-1:0] refill_length;
        logic [CNT_W-1:0] error_total;
        logic [CNT_W-1:0] drop_total;
    } result_t;

endpackage

// ===== src/rcrc_apb_regs.sv =====
// APB configuration register file: holds buffer_length.
// Depends on rcrc_pkg.
module rcrc_apb_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rcrc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rcrc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rcrc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [rcrc_pkg::LEN_W-1:0]          buffer_length
);

    logic [rcrc_pkg::LEN_W-1:0] buf_len_reg;
    logic [rcrc_pkg::LEN_W-1:0] buf_len_next;
    logic                       wr_en;
    logic                       sel_buf_len;

    assign pready      = 1'b1;
    assign sel_buf_len = (paddr[2] == rcrc_pkg::REG_BUFFER_LENGTH);
    assign wr_en       = psel && penable && pwrite && sel_buf_len;

    always_comb
    begin
        buf_len_next = buf_len_reg;
        if (wr_en)
        begin
            buf_len_next = pwdata[rcrc_pkg::LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_len_reg <= rcrc_pkg::BUF_LEN_RESET;
        end
        else
        begin
            buf_len_reg <= buf_len_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_buf_len)
        begin
            prdata = rcrc_pkg::APB_DATA_W'(buf_len_reg);
        end
    end

    assign buffer_length = buf_len_reg;

endmodule

// ===== src/rcrc_core.sv =====
// Ring consumer state and single-pass classification of one completion item.
// Depends on rcrc_pkg.
module rcrc_core
#(
    parameter int COMPLETION_RING_DEPTH = 256,
    parameter int BUFFER_RING_DEPTH     = 128,
    parameter int SLOT_W = $clog2(COMPLETION_RING_DEPTH),
    parameter int RIDX_W = $clog2(BUFFER_RING_DEPTH)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  rcrc_pkg::item_t             item,
    input  logic [rcrc_pkg::LEN_W-1:0]  buffer_length,
    output rcrc_pkg::result_t           result,
    output logic [RIDX_W-1:0]           refill_index,
    output logic [SLOT_W-1:0]           next_slot
);

    localparam int FILL_W = $clog2(2 * BUFFER_RING_DEPTH);
    localparam int BIDX_CMP_W = rcrc_pkg::BUF_IDX_W + 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(COMPLETION_RING_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(2 * BUFFER_RING_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_HALF = FILL_W'(BUFFER_RING_DEPTH);

    logic [SLOT_W-1:0]          slot_reg, slot_next;
    logic                       exp_gen_reg, exp_gen_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic [rcrc_pkg::CNT_W-1:0] err_cnt_reg, err_cnt_next;
    logic [rcrc_pkg::CNT_W-1:0] drop_cnt_reg, drop_cnt_next;

    logic gen_match;
    logic good_frame;
    logic in_ring;

    assign gen_match  = (item.entry_gen == exp_gen_reg);
    assign good_frame = item.end_flag && item.start_flag && !item.error_flag
                        && (item.frame_length <= buffer_length);
    assign in_ring    = ({1'b0, item.buffer_index} < BIDX_CMP_W'(BUFFER_RING_DEPTH));

    always_comb
    begin
        slot_next     = slot_reg;
        exp_gen_next  = exp_gen_reg;
        fill_next     = fill_reg;
        err_cnt_next  = err_cnt_reg;
        drop_cnt_next = drop_cnt_reg;
        result              = '0;
        result.outcome      = rcrc_pkg::OUT_NOT_READY;
        refill_index        = '0;

        if (gen_match)
        begin
            if (good_frame)
            begin
                result.outcome = (in_ring && item.queue_room) ? rcrc_pkg::OUT_DELIVERED
                                                              : rcrc_pkg::OUT_REFUSED;
                if (in_ring)
                begin
                    result.refill_valid  = 1'b1;
                    refill_index         = item.buffer_index[RIDX_W-1:0];
                    // first half of the fill cycle carries generation 1
                    result.refill_gen    = (fill_reg < FILL_HALF);
                    result.refill_length = buffer_length;
                    fill_next = (fill_reg == FILL_LAST) ? '0 : fill_reg + 1'b1;
                end
            end
            else if (item.end_flag && item.error_flag)
            begin
                result.outcome = rcrc_pkg::OUT_ERROR;
                err_cnt_next   = err_cnt_reg + 1'b1;
            end
            else
            begin
                result.outcome = rcrc_pkg::OUT_DROPPED;
                drop_cnt_next  = drop_cnt_reg + 1'b1;
            end

            if (slot_reg == SLOT_LAST)
            begin
                slot_next    = '0;
                exp_gen_next = !exp_gen_reg;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end

        result.error_total = err_cnt_next;
        result.drop_total  = drop_cnt_next;
        next_slot          = slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= '0;
            exp_gen_reg  <= 1'b1;
            fill_reg     <= FILL_HALF;
            err_cnt_reg  <= '0;
            drop_cnt_reg <= '0;
        end
        else if (advance)
        begin
            slot_reg     <= slot_next;
            exp_gen_reg  <= exp_gen_next;
            fill_reg     <= fill_next;
            err_cnt_reg  <= err_cnt_next;
            drop_cnt_reg <= drop_cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_LAST)
        else $error("consumer slot out of ring");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_LAST)
        else $error("fill counter out of range");

    a_not_ready_holds: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !gen_match |=> $stable(slot_reg) && $stable(exp_gen_reg)
            && $stable(fill_reg))
        else $error("state moved on a not-ready item");

    a_refill_steps_fill: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.refill_valid |=> fill_reg != $past(fill_reg))
        else $error("refill did not advance fill counter");

    a_err_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.outcome != rcrc_pkg::OUT_ERROR |=> $stable(err_cnt_reg))
        else $error("error count moved without an error outcome");
`endif

endmodule

// ===== src/rx_completion_ring_consumer_top.sv =====
// Top level of the receive completion ring consumer: input register,
// result register and handshakes. Depends on rcrc_pkg, rcrc_apb_regs, rcrc_core.
//
//   channel   direction  handshake             payload
//   in        sink       in_valid / in_stall   entry_gen .. queue_room
//   out       source     out_valid / out_stall outcome .. drop_total
//   cfg       APB slave  psel/penable/pready   paddr, pwdata, prdata
//
// One item per cycle sustained while out_stall is low; an accepted item passes
// through the input register and then the result register, where out_valid
// rises and the result waits to be taken.
// The consumer state updates when an item moves into the result register.
// Reset clears slot 0, expected generation 1, fill count at ring depth,
// totals 0, buffer_length 2048.
// A stalled result holds; the input register still takes one more item.
module rx_completion_ring_consumer_top
#(
    parameter int COMPLETION_RING_DEPTH = 256,
    parameter int BUFFER_RING_DEPTH     = 128
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [rcrc_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [rcrc_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [rcrc_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready,

    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    entry_gen,
    input  logic                                    start_flag,
    input  logic                                    end_flag,
    input  logic                                    error_flag,
    input  logic [rcrc_pkg::LEN_W-1:0]              frame_length,
    input  logic [rcrc_pkg::BUF_IDX_W-1:0]          buffer_index,
    input  logic                                    queue_room,

    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [2:0]                              outcome,
    output logic                                    refill_valid,
    output logic [$clog2(BUFFER_RING_DEPTH)-1:0]    refill_index,
    output logic                                    refill_gen,
    output logic [rcrc_pkg::LEN_W-1:0]              refill_length,
    output logic [$clog2(COMPLETION_RING_DEPTH)-1:0] next_slot,
    output logic [rcrc_pkg::CNT_W-1:0]              error_total,
    output logic [rcrc_pkg::CNT_W-1:0]              drop_total
);

    localparam int SLOT_W = $clog2(COMPLETION_RING_DEPTH);
    localparam int RIDX_W = $clog2(BUFFER_RING_DEPTH);

    logic [rcrc_pkg::LEN_W-1:0] buffer_length;

    logic              in_full_reg, in_full_next;
    rcrc_pkg::item_t   item_reg;
    logic              out_valid_reg, out_valid_next;
    rcrc_pkg::result_t res_reg;
    logic [RIDX_W-1:0] ridx_reg;
    logic [SLOT_W-1:0] slot_out_reg;

    logic              accept;
    logic              advance;
    rcrc_pkg::result_t core_result;
    logic [RIDX_W-1:0] core_ridx;
    logic [SLOT_W-1:0] core_slot;

    rcrc_apb_regs u_regs
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .buffer_length (buffer_length)
    );

    rcrc_core
    #(
        .COMPLETION_RING_DEPTH (COMPLETION_RING_DEPTH),
        .BUFFER_RING_DEPTH     (BUFFER_RING_DEPTH),
        .SLOT_W                (SLOT_W),
        .RIDX_W                (RIDX_W)
    )
    u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .item          (item_reg),
        .buffer_length (buffer_length),
        .result        (core_result),
        .refill_index  (core_ridx),
        .next_slot     (core_slot)
    );

    // item moves on when the result register is empty or being drained
    assign advance  = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign in_full_next   = accept || (in_full_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.entry_gen    <= entry_gen;
            item_reg.start_flag   <= start_flag;
            item_reg.end_flag     <= end_flag;
            item_reg.error_flag   <= error_flag;
            item_reg.frame_length <= frame_length;
            item_reg.buffer_index <= buffer_index;
            item_reg.queue_room   <= queue_room;
        end
        if (advance)
        begin
            res_reg      <= core_result;
            ridx_reg     <= core_ridx;
            slot_out_reg <= core_slot;
        end
    end

    assign out_valid     = out_valid_reg;
    assign outcome       = res_reg.outcome;
    assign refill_valid  = res_reg.refill_valid;
    assign refill_index  = ridx_reg;
    assign refill_gen    = res_reg.refill_gen;
    assign refill_length = res_reg.refill_length;
    assign next_slot     = slot_out_reg;
    assign error_total   = res_reg.error_total;
    assign drop_total    = res_reg.drop_total;

endmodule

// ===== dv/tb_rx_completion_ring_consumer_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for rx_completion_ring_consumer_top: directed and random
// completion entries, buffer_length changes over APB, random idle and stall phases.
// Depends on rcrc_pkg and the block's RTL only.
module tb_rx_completion_ring_consumer_top;

    localparam int CRD        = 256;
    localparam int BRD        = 128;
    localparam int IDX_W      = $clog2(BRD);
    localparam int SLOT_W     = $clog2(CRD);
    localparam int CYCLE_CAP  = 200000;
    localparam int DRAIN_WAIT = 8;
    localparam logic [rcrc_pkg::APB_ADDR_W-1:0] BUF_LEN_ADDR =
        {rcrc_pkg::REG_BUFFER_LENGTH, 2'b00};

    typedef struct packed {
        rcrc_pkg::outcome_t            outcome;
        logic                          refill_valid;
        logic [IDX_W-1:0]              refill_index;
        logic                          refill_gen;
        logic [rcrc_pkg::LEN_W-1:0]    refill_length;
        logic [SLOT_W-1:0]             next_slot;
        logic [rcrc_pkg::CNT_W-1:0]    error_total;
        logic [rcrc_pkg::CNT_W-1:0]    drop_total;
    } completion_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [rcrc_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [rcrc_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [rcrc_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    logic            in_valid = 1'b0;
    logic            in_stall;
    rcrc_pkg::item_t cur_entry = '0;

    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [2:0]                 outcome;
    logic                       refill_valid;
    logic [IDX_W-1:0]           refill_index;
    logic                       refill_gen;
    logic [rcrc_pkg::LEN_W-1:0] refill_length;
    logic [SLOT_W-1:0]          next_slot;
    logic [rcrc_pkg::CNT_W-1:0] error_total;
    logic [rcrc_pkg::CNT_W-1:0] drop_total;

    // predicted consumer state
    logic [rcrc_pkg::LEN_W-1:0] buf_len_model = rcrc_pkg::BUF_LEN_RESET;
    logic [SLOT_W-1:0]          slot_model = '0;
    logic                       gen_model = 1'b1;
    logic [IDX_W:0]             fill_model = (IDX_W+1)'(BRD);
    logic [rcrc_pkg::CNT_W-1:0] errors_model = '0;
    logic [rcrc_pkg::CNT_W-1:0] drops_model = '0;

    // generator's own view of ownership, so most entries arrive owned
    int   stim_slot = 0;
    logic stim_gen = 1'b1;

    rcrc_pkg::item_t pending_entries[$];
    completion_t     expected_results[$];
    completion_t     want;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int results_seen = 0;
    int refills_seen = 0;
    int cycles = 0;
    int outcome_hits[8];

    rx_completion_ring_consumer_top #(
        .COMPLETION_RING_DEPTH(CRD),
        .BUFFER_RING_DEPTH(BRD)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .entry_gen(cur_entry.entry_gen),
        .start_flag(cur_entry.start_flag),
        .end_flag(cur_entry.end_flag),
        .error_flag(cur_entry.error_flag),
        .frame_length(cur_entry.frame_length),
        .buffer_index(cur_entry.buffer_index),
        .queue_room(cur_entry.queue_room),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .outcome(outcome),
        .refill_valid(refill_valid),
        .refill_index(refill_index),
        .refill_gen(refill_gen),
        .refill_length(refill_length),
        .next_slot(next_slot),
        .error_total(error_total),
        .drop_total(drop_total)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Classify one entry (not ready unless owned), update the consumer state, return the result.
    function automatic completion_t consume_entry(input rcrc_pkg::item_t e);
        completion_t r;
        logic        in_ring;
        r = '0;
        r.outcome = rcrc_pkg::OUT_NOT_READY;
        if (e.entry_gen == gen_model)
        begin
            if (e.end_flag && e.start_flag && !e.error_flag
                && e.frame_length <= buf_len_model)
            begin
                in_ring = e.buffer_index < BRD;
                r.outcome = (in_ring && e.queue_room) ? rcrc_pkg::OUT_DELIVERED
                                                      : rcrc_pkg::OUT_REFUSED;
                if (in_ring)
                begin
                    r.refill_valid = 1'b1;
                    r.refill_index = e.buffer_index[IDX_W-1:0];
                    r.refill_gen = ~fill_model[IDX_W];
                    r.refill_length = buf_len_model;
                    fill_model = fill_model + 1'b1;
                end
            end
            else if (e.end_flag && e.error_flag)
            begin
                r.outcome = rcrc_pkg::OUT_ERROR;
                errors_model = errors_model + 1'b1;
            end
            else
            begin
                r.outcome = rcrc_pkg::OUT_DROPPED;
                drops_model = drops_model + 1'b1;
            end
            if (slot_model == SLOT_W'(CRD - 1))
            begin
                slot_model = '0;
                gen_model = ~gen_model;
            end
            else
                slot_model = slot_model + 1'b1;
        end
        r.next_slot = slot_model;
        r.error_total = errors_model;
        r.drop_total = drops_model;
        return r;
    endfunction

    task automatic compare_field(input string field_name, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH %s at result %0d: expected 0x%0h, got 0x%0h",
                         field_name, results_seen, exp_val, act_val);
        end
    endtask

    task automatic queue_entry(input bit owned, input bit sop, input bit eop, input bit err,
                               input logic [rcrc_pkg::LEN_W-1:0] len,
                               input logic [rcrc_pkg::BUF_IDX_W-1:0] idx, input bit room);
        rcrc_pkg::item_t e;
        e.entry_gen = owned ? stim_gen : ~stim_gen;
        e.start_flag = sop;
        e.end_flag = eop;
        e.error_flag = err;
        e.frame_length = len;
        e.buffer_index = idx;
        e.queue_room = room;
        pending_entries.push_back(e);
        if (owned)
        begin
            stim_slot++;
            if (stim_slot == CRD)
            begin
                stim_slot = 0;
                stim_gen = ~stim_gen;
            end
        end
    endtask

    // Mostly owned, good single-buffer frames; the rest broken or foreign.
    task automatic queue_random(input int count, input logic [rcrc_pkg::LEN_W-1:0] blen);
        bit                             sop;
        bit                             eop;
        bit                             err;
        logic [rcrc_pkg::LEN_W-1:0]     len;
        logic [rcrc_pkg::BUF_IDX_W-1:0] idx;
        int                             roll;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 60)
            begin
                sop = 1'b1;
                eop = 1'b1;
                err = ($urandom_range(19) == 0);
            end
            else
            begin
                sop = 1'($urandom_range(1));
                eop = 1'($urandom_range(1));
                err = 1'($urandom_range(1));
            end
            case ($urandom_range(9))
                0, 1, 2, 3, 4: len = rcrc_pkg::LEN_W'($urandom_range(blen));
                5:             len = '0;
                6:             len = blen;
                7:             len = blen + 1'b1;
                default:       len = rcrc_pkg::LEN_W'($urandom);
            endcase
            roll = $urandom_range(99);
            if (roll < 75)
                idx = rcrc_pkg::BUF_IDX_W'($urandom_range(BRD - 1));
            else if (roll < 85)
                idx = rcrc_pkg::BUF_IDX_W'($urandom_range(2**rcrc_pkg::BUF_IDX_W - 1, BRD));
            else
                idx = rcrc_pkg::BUF_IDX_W'($urandom);
            queue_entry($urandom_range(99) < 88, sop, eop, err, len, idx,
                        $urandom_range(99) < 75);
        end
    endtask

    // Block is idle once every queued item has gone in and every result has come out.
    task automatic settle();
        while (pending_entries.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_buffer_length(input logic [31:0] value);
        logic [31:0] readback;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= BUF_LEN_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        buf_len_model = value[rcrc_pkg::LEN_W-1:0];
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        readback = prdata;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        compare_field("buffer_length readback", 32'(buf_len_model),
                      32'(readback[rcrc_pkg::LEN_W-1:0]));
    endtask

    // input side: hold while stalled, otherwise maybe take the next pending item
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(consume_entry(cur_entry));
            if (!in_valid || !in_stall)
            begin
                if (pending_entries.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_entry <= pending_entries.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output side: check each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                outcome_hits[outcome]++;
                if (refill_valid)
                    refills_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("MISMATCH result %0d arrived with nothing predicted",
                                 results_seen);
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("outcome", 32'(want.outcome), 32'(outcome));
                    compare_field("refill_valid", 32'(want.refill_valid), 32'(refill_valid));
                    compare_field("refill_index", 32'(want.refill_index), 32'(refill_index));
                    compare_field("refill_gen", 32'(want.refill_gen), 32'(refill_gen));
                    compare_field("refill_length", 32'(want.refill_length),
                                  32'(refill_length));
                    compare_field("next_slot", 32'(want.next_slot), 32'(next_slot));
                    compare_field("error_total", want.error_total, error_total);
                    compare_field("drop_total", want.drop_total, drop_total);
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_CAP)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles, expected_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // reset length 2048, no idling: directed cases first
        queue_entry(0, 1, 1, 0, 14'd100, 12'd5, 1);      // not owned yet
        queue_entry(1, 1, 1, 0, 14'd2048, 12'd0, 1);     // exactly buffer size
        queue_entry(1, 1, 1, 0, 14'd0, 12'd127, 0);      // queue full, last descriptor
        queue_entry(1, 1, 1, 0, 14'd50, 12'd128, 1);     // descriptor past the ring
        queue_entry(1, 1, 1, 0, 14'd2049, 12'd3, 1);     // one byte too long
        queue_entry(1, 1, 1, 0, 14'h3FFF, 12'hFFF, 0);   // max length and index
        queue_entry(1, 1, 1, 1, 14'd64, 12'd10, 1);      // errored single buffer
        queue_entry(1, 0, 1, 1, 14'd64, 12'd11, 1);      // errored tail
        queue_entry(1, 1, 0, 1, 14'd64, 12'd12, 1);      // start only, error set
        queue_entry(1, 0, 0, 0, 14'd0, 12'd13, 1);       // middle buffer
        queue_entry(1, 0, 1, 0, 14'd300, 12'd14, 1);     // clean tail
        queue_entry(1, 1, 1, 0, 14'd1500, 12'hFFF, 1);   // past the ring, room
        queue_entry(0, 1, 1, 0, 14'd1500, 12'd20, 1);    // not owned again
        queue_entry(1, 1, 1, 0, 14'd1, 12'd64, 1);
        queue_random(100, buf_len_model);
        settle();

        write_buffer_length(32'h0000_3FFF);
        send_idle_pct = 66;
        recv_stall_pct = 0;
        queue_random(150, buf_len_model);
        settle();

        write_buffer_length(32'h0000_0001);
        send_idle_pct = 0;
        recv_stall_pct = 66;
        queue_random(120, buf_len_model);
        settle();

        // upper bits are ignored, so this sets a zero buffer length
        write_buffer_length(32'hFFFF_C000);
        send_idle_pct = 38;
        recv_stall_pct = 38;
        queue_entry(1, 1, 1, 0, 14'd0, 12'd7, 1);
        queue_entry(1, 1, 1, 0, 14'd1, 12'd8, 1);
        queue_entry(1, 1, 1, 1, 14'd0, 12'd9, 0);
        queue_random(120, buf_len_model);
        settle();

        write_buffer_length($urandom);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random(150, buf_len_model);
        settle();

        write_buffer_length(32'(rcrc_pkg::BUF_LEN_RESET));
        send_idle_pct = 38;
        recv_stall_pct = 38;
        queue_random(110, buf_len_model);
        settle();

        mismatches += expected_results.size();
        $display("covered %0d results: %0d delivered, %0d refused, %0d errors, %0d drops,",
                 results_seen, outcome_hits[rcrc_pkg::OUT_DELIVERED],
                 outcome_hits[rcrc_pkg::OUT_REFUSED],
                 outcome_hits[rcrc_pkg::OUT_ERROR], outcome_hits[rcrc_pkg::OUT_DROPPED]);
        $display("  %0d not ready, %0d refills, 6 buffer lengths incl. 0 and max, %0d cycles",
                 outcome_hits[rcrc_pkg::OUT_NOT_READY], refills_seen, cycles);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
